FILE: hw/rtl/dcls_pkg.sv
`timescale 1ns / 1ps

package dcls_pkg;

  localparam int SERVERS_DEF = 4;
  localparam int POINTS_DEF  = 1024;

  localparam int SEL_W   = 2;
  localparam int POS_W   = 10;
  localparam int IDX_W   = 2;
  localparam int COST_W  = 11;
  localparam int TOTAL_W = 32;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [SEL_W-1:0] server_select;
    logic [POS_W-1:0] point;
    logic             end_of_sequence;
  } in_t;

  typedef struct packed {
    logic               covered;
    logic [IDX_W-1:0]   served_index;
    logic               partner_moved;
    logic [IDX_W-1:0]   partner_index;
    logic [COST_W-1:0]  request_cost;
    logic [TOTAL_W-1:0] total_cost;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_request;
    logic scan_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/dcls_ctrl.sv
`timescale 1ns / 1ps

module dcls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dcls_pkg::dp_status_t status_i,
  output dcls_pkg::dp_cmd_t    cmd_o
);
  import dcls_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status_i.is_request || status_i.scan_last) state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_step = status_i.is_request;
      end
      ST_RESOLVE: begin
        cmd_o.commit = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit while output register still held");

  a_capture_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_SCAN))
    else $error("captured transaction did not enter scan");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("result lost after commit");

endmodule

FILE: hw/rtl/dcls_datapath.sv
`timescale 1ns / 1ps

module dcls_datapath #(
  parameter int SERVERS = dcls_pkg::SERVERS_DEF,
  parameter int POINTS  = dcls_pkg::POINTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcls_pkg::in_t        in_i,
  input  dcls_pkg::dp_cmd_t    cmd_i,
  output dcls_pkg::dp_status_t status_o,
  output dcls_pkg::out_t       out_o
);
  import dcls_pkg::*;

  localparam int IdxW     = $clog2(SERVERS);
  localparam int PtMaxInt = (POINTS - 1 > (1 << POS_W) - 1) ? (1 << POS_W) - 1 : POINTS - 1;
  localparam logic [POS_W-1:0] PtMax    = POS_W'(PtMaxInt);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(SERVERS - 1);

  // captured transaction
  logic             op_q;
  logic [SEL_W-1:0] sel_q;
  logic [POS_W-1:0] pt_q;
  logic             eos_q;
  logic [POS_W-1:0] pt_sat;

  // scan state
  logic [IdxW-1:0]  cnt_q;
  logic             covered_q, has_l_q, has_r_q;
  logic [IdxW-1:0]  l_idx_q, r_idx_q;
  logic [POS_W-1:0] l_pos_q, r_pos_q;
  logic [POS_W-1:0] pos_rd;

  logic [POS_W-1:0]   pos_q [SERVERS];
  logic [TOTAL_W-1:0] total_q;
  out_t               out_q;

  assign pt_sat = (in_i.point > PtMax) ? PtMax : in_i.point;
  assign pos_rd = pos_q[cnt_q];

  assign status_o.is_request = (op_q == OP_REQUEST);
  assign status_o.scan_last  = (cnt_q == LastIdx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_i.operation;
      sel_q <= in_i.server_select;
      pt_q  <= pt_sat;
      eos_q <= in_i.end_of_sequence;
    end
  end

  // nearest left / right neighbor search, one server per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      covered_q <= 1'b0;
      has_l_q   <= 1'b0;
      has_r_q   <= 1'b0;
    end else if (cmd_i.capture) begin
      cnt_q     <= '0;
      covered_q <= 1'b0;
      has_l_q   <= 1'b0;
      has_r_q   <= 1'b0;
    end else if (cmd_i.scan_step) begin
      cnt_q <= cnt_q + 1'b1;
      if (pos_rd == pt_q) covered_q <= 1'b1;
      if (pos_rd < pt_q) begin
        if (!has_l_q || pos_rd > l_pos_q) has_l_q <= 1'b1;
      end else begin
        if (!has_r_q || pos_rd < r_pos_q) has_r_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      if (pos_rd < pt_q) begin
        if (!has_l_q || pos_rd > l_pos_q) begin
          l_idx_q <= cnt_q;
          l_pos_q <= pos_rd;
        end
      end else begin
        if (!has_r_q || pos_rd < r_pos_q) begin
          r_idx_q <= cnt_q;
          r_pos_q <= pos_rd;
        end
      end
    end
  end

  // resolve: load write or double-coverage move
  logic [POS_W-1:0]   dl, dr;
  logic [COST_W-1:0]  cost;
  logic               pmoved;
  logic [IdxW-1:0]    served, pidx;
  logic               we_a, we_b;
  logic [IdxW-1:0]    wa_idx, wb_idx;
  logic [POS_W-1:0]   wa_pos, wb_pos;
  logic [IdxW+SEL_W-1:0] sel_ext;
  logic [IdxW+IDX_W-1:0] served_ext, pidx_ext;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] new_total;

  assign dl      = pt_q - l_pos_q;
  assign dr      = r_pos_q - pt_q;
  assign sel_ext = {{IdxW{1'b0}}, sel_q};

  always_comb begin
    cost   = '0;
    pmoved = 1'b0;
    served = '0;
    pidx   = '0;
    we_a   = 1'b0;
    we_b   = 1'b0;
    wa_idx = l_idx_q;
    wb_idx = r_idx_q;
    wa_pos = pt_q;
    wb_pos = pt_q;
    if (op_q == OP_LOAD) begin
      we_a   = (32'(sel_q) < SERVERS);
      wa_idx = sel_ext[IdxW-1:0];
    end else if (!covered_q) begin
      if (has_l_q && has_r_q) begin
        pmoved = 1'b1;
        we_a   = 1'b1;
        we_b   = 1'b1;
        if (dl < dr) begin
          wb_pos = r_pos_q - dl;
          served = l_idx_q;
          pidx   = r_idx_q;
          cost   = {dl, 1'b0};
        end else begin
          wa_pos = l_pos_q + dr;
          served = r_idx_q;
          pidx   = l_idx_q;
          cost   = {dr, 1'b0};
        end
      end else if (has_r_q) begin
        we_b   = 1'b1;
        served = r_idx_q;
        cost   = {1'b0, dr};
      end else if (has_l_q) begin
        we_a   = 1'b1;
        served = l_idx_q;
        cost   = {1'b0, dl};
      end
    end
  end

  assign served_ext = {{IDX_W{1'b0}}, served};
  assign pidx_ext   = {{IDX_W{1'b0}}, pidx};
  assign sum        = {1'b0, total_q} + (TOTAL_W + 1)'(cost);
  assign new_total  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (we_a) pos_q[wa_idx] <= wa_pos;
      if (we_b) pos_q[wb_idx] <= wb_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.commit) begin
      total_q <= eos_q ? '0 : new_total;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.covered       <= (op_q == OP_REQUEST) && covered_q;
      out_q.served_index  <= served_ext[IDX_W-1:0];
      out_q.partner_moved <= pmoved;
      out_q.partner_index <= pidx_ext[IDX_W-1:0];
      out_q.request_cost  <= cost;
      out_q.total_cost    <= new_total;
    end
  end

  assign out_o = out_q;

  a_covered_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && covered_q && op_q == OP_REQUEST) |-> (cost == '0 && !we_a && !we_b))
    else $error("covered request moved a server");

  a_scan_only_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (op_q == OP_REQUEST))
    else $error("scan running for a load");

endmodule

FILE: hw/rtl/double_coverage_line_server_mover.sv
`timescale 1ns / 1ps
// A load passes through idle, scan and resolve without any scan step; a request
//   also runs the neighbor scan, one server per cycle, before resolve.
// A new transaction is accepted only once the previous one has committed, and resolve
//   waits for a free output register; the sequential scan limits request throughput.
// Reset (rst_ni, async, active low): FSM idle, output empty, cost total zero;
//   server positions are not reset and must be loaded before use.

module double_coverage_line_server_mover #(
  parameter int SERVERS = dcls_pkg::SERVERS_DEF,
  parameter int POINTS  = dcls_pkg::POINTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // input channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dcls_pkg::in_t  in_i,
  // result channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dcls_pkg::out_t out_o
);
  import dcls_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: idle -> scan (no scan steps for loads) -> resolve. Resolve waits for
  // the output register to be free, so a finished result can sit there while
  // the next transaction is accepted and scanned.
  dcls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: server position registers, neighbor search, move/cost logic,
  // saturating cost total and the output register.
  dcls_datapath #(
    .SERVERS (SERVERS),
    .POINTS  (POINTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

endmodule
